// ===== design/lkv_pkg.sv =====
// Shared types and constants for the LRU key-value cache.
// Used by lkv_ctrl, lkv_datapath, the top level and the checker; no dependencies.
`default_nettype none

package lkv_pkg;

	// Table geometry
	localparam int ENTRIES = 16;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int RANK_W  = IDX_W;
	localparam int CNT_W   = 5;
	localparam int KEY_W   = 32;
	localparam int VAL_W   = 32;
	localparam int ACT_W   = 2;

	// Request kinds
	typedef enum logic [ACT_W-1:0] {
		ACT_GET      = 2'd0,
		ACT_PUT      = 2'd1,
		ACT_CONTAINS = 2'd2
	} action_t;

	// Controller states
	typedef enum logic [1:0] {
		ST_IDLE   = 2'd0,
		ST_LOOKUP = 2'd1,
		ST_UPDATE = 2'd2
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load;
		logic lookup;
		logic commit;
	} ctrl_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic out_stall;
	} dp_status_t;

endpackage

`default_nettype wire

// ===== design/lkv_ctrl.sv =====
// Request sequencer for the LRU key-value cache.
// Steps each item through accept, lookup and commit; depends on lkv_pkg.
`default_nettype none

module lkv_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire lkv_pkg::dp_status_t status,
	output lkv_pkg::ctrl_cmd_t      cmd
);

	lkv_pkg::state_t state_q;
	lkv_pkg::state_t state_next;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lkv_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Next state and commands
	always_comb begin
		state_next = state_q;
		in_ready   = 1'b0;
		cmd        = '0;
		case (state_q)
			lkv_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load   = 1'b1;
					state_next = lkv_pkg::ST_LOOKUP;
				end
			end
			lkv_pkg::ST_LOOKUP: begin
				cmd.lookup = 1'b1;
				state_next = lkv_pkg::ST_UPDATE;
			end
			lkv_pkg::ST_UPDATE: begin
				// hold until the result register can take the new item
				if (!status.out_stall) begin
					cmd.commit = 1'b1;
					state_next = lkv_pkg::ST_IDLE;
				end
			end
			default: begin
				state_next = lkv_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== design/lkv_datapath.sv =====
// Entry table, associative lookup, recency ranks and result register.
// Driven by commands from lkv_ctrl; depends on lkv_pkg.
`default_nettype none

module lkv_datapath (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire lkv_pkg::ctrl_cmd_t                cmd,
	output lkv_pkg::dp_status_t                    status,
	input  wire logic                              cfg_we,
	input  wire logic        [lkv_pkg::CNT_W-1:0]  cfg_wdata,
	input  wire logic        [lkv_pkg::ACT_W-1:0]  in_action,
	input  wire logic signed [lkv_pkg::KEY_W-1:0]  in_key,
	input  wire logic signed [lkv_pkg::VAL_W-1:0]  in_value,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic                                   out_found,
	output logic signed      [lkv_pkg::VAL_W-1:0]  out_read_value,
	output logic             [lkv_pkg::CNT_W-1:0]  out_entry_count
);

	localparam int N = lkv_pkg::ENTRIES;

	// Table state
	logic signed [lkv_pkg::KEY_W-1:0]  key_q   [N];
	logic signed [lkv_pkg::VAL_W-1:0]  val_q   [N];
	logic        [lkv_pkg::RANK_W-1:0] rank_q  [N];
	logic        [N-1:0]               valid_q;
	logic        [lkv_pkg::CNT_W-1:0]  occ_q;
	logic        [lkv_pkg::CNT_W-1:0]  cap_q;

	// Request registers
	logic        [lkv_pkg::ACT_W-1:0]  req_act_q;
	logic signed [lkv_pkg::KEY_W-1:0]  req_key_q;
	logic signed [lkv_pkg::VAL_W-1:0]  req_val_q;

	// Lookup stage registers
	logic                              hit_s1;
	logic        [lkv_pkg::IDX_W-1:0]  hit_idx_s1;
	logic        [lkv_pkg::RANK_W-1:0] hit_rank_s1;
	logic signed [lkv_pkg::VAL_W-1:0]  hit_val_s1;
	logic        [lkv_pkg::IDX_W-1:0]  lru_idx_s1;
	logic        [lkv_pkg::IDX_W-1:0]  free_idx_s1;

	// Result register
	logic                              out_valid_q;
	logic                              out_found_q;
	logic signed [lkv_pkg::VAL_W-1:0]  out_rd_q;
	logic        [lkv_pkg::CNT_W-1:0]  out_cnt_q;

	// Lookup logic
	logic        [lkv_pkg::CNT_W-1:0]  occ_m1;
	logic        [lkv_pkg::RANK_W-1:0] lru_rank;
	logic        [N-1:0]               match;
	logic        [N-1:0]               lru_match;
	logic                              hit;
	logic        [lkv_pkg::IDX_W-1:0]  hit_idx;
	logic        [lkv_pkg::IDX_W-1:0]  lru_idx;
	logic        [lkv_pkg::IDX_W-1:0]  free_idx;

	// Commit logic
	logic        [lkv_pkg::CNT_W-1:0]  cap_eff;
	logic                              is_get;
	logic                              is_put;
	logic                              is_contains;
	logic                              do_put;
	logic                              upd_hit;
	logic                              evict;
	logic                              insert;
	logic                              touch;
	logic                              write_kv;
	logic        [lkv_pkg::IDX_W-1:0]  tgt_idx;
	logic        [lkv_pkg::RANK_W-1:0] tgt_rank;
	logic        [lkv_pkg::CNT_W-1:0]  occ_next;
	logic                              res_found;
	logic signed [lkv_pkg::VAL_W-1:0]  res_rd;

	// Valid ranks form 0..occ-1, so the least recent entry holds rank occ-1
	assign occ_m1   = occ_q - lkv_pkg::CNT_W'(1);
	assign lru_rank = occ_m1[lkv_pkg::RANK_W-1:0];

	// Compare all entries in parallel
	always_comb begin
		for (int i = 0; i < N; i++) begin
			match[i]     = valid_q[i] && (key_q[i] == req_key_q);
			lru_match[i] = valid_q[i] && (rank_q[i] == lru_rank);
		end
	end

	// Encode the lowest matching, least recent and free slots
	always_comb begin
		hit_idx  = '0;
		lru_idx  = '0;
		free_idx = '0;
		for (int i = N - 1; i >= 0; i--) begin
			if (match[i]) begin
				hit_idx = lkv_pkg::IDX_W'(i);
			end
			if (lru_match[i]) begin
				lru_idx = lkv_pkg::IDX_W'(i);
			end
			if (!valid_q[i]) begin
				free_idx = lkv_pkg::IDX_W'(i);
			end
		end
	end

	assign hit = |match;

	// Register lookup results
	always_ff @(posedge clk) begin
		if (cmd.lookup) begin
			hit_s1      <= hit;
			hit_idx_s1  <= hit_idx;
			hit_rank_s1 <= rank_q[hit_idx];
			hit_val_s1  <= val_q[hit_idx];
			lru_idx_s1  <= lru_idx;
			free_idx_s1 <= free_idx;
		end
	end

	// Latch the accepted item
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_act_q <= in_action;
			req_key_q <= in_key;
			req_val_q <= in_value;
		end
	end

	// Decide the table update
	always_comb begin
		cap_eff     = (cap_q > lkv_pkg::CNT_W'(N)) ? lkv_pkg::CNT_W'(N) : cap_q;
		is_get      = (req_act_q == lkv_pkg::ACT_GET);
		is_put      = (req_act_q == lkv_pkg::ACT_PUT);
		is_contains = (req_act_q == lkv_pkg::ACT_CONTAINS);
		do_put      = is_put && (cap_eff != '0);
		upd_hit     = do_put && hit_s1;
		evict       = do_put && !hit_s1 && (occ_q >= cap_eff);
		insert      = do_put && !hit_s1 && (occ_q < cap_eff);
		write_kv    = upd_hit || evict || insert;
		touch       = write_kv || (is_get && hit_s1);
		tgt_idx     = hit_s1 ? hit_idx_s1 : (evict ? lru_idx_s1 : free_idx_s1);
		tgt_rank    = hit_s1 ? hit_rank_s1 : lru_rank;
		occ_next    = insert ? occ_q + lkv_pkg::CNT_W'(1) : occ_q;
		res_found   = hit_s1 && (is_get || is_put || is_contains);
		res_rd      = (is_get && hit_s1) ? hit_val_s1 : '0;
	end

	// Key, value and rank arrays
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			for (int i = 0; i < N; i++) begin
				if (write_kv && (tgt_idx == lkv_pkg::IDX_W'(i))) begin
					key_q[i] <= req_key_q;
					val_q[i] <= req_val_q;
				end
				if (touch) begin
					if (tgt_idx == lkv_pkg::IDX_W'(i)) begin
						rank_q[i] <= '0;
					end else if (valid_q[i] && (insert || (rank_q[i] < tgt_rank))) begin
						rank_q[i] <= rank_q[i] + lkv_pkg::RANK_W'(1);
					end
				end
			end
		end
	end

	// Valid bits, occupancy and capacity
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			occ_q   <= '0;
			cap_q   <= lkv_pkg::CNT_W'(N);
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (cmd.commit) begin
				occ_q <= occ_next;
				if (insert) begin
					valid_q[free_idx_s1] <= 1'b1;
				end
			end
		end
	end

	// Result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_found_q <= res_found;
			out_rd_q    <= res_rd;
			out_cnt_q   <= occ_next;
		end
	end

	assign status.out_stall = out_valid_q && !out_ready;
	assign out_valid        = out_valid_q;
	assign out_found        = out_found_q;
	assign out_read_value   = out_rd_q;
	assign out_entry_count  = out_cnt_q;

endmodule

`default_nettype wire

// ===== design/lru_key_value_cache.sv =====
// Top level of the LRU key-value cache: stream ports and configuration port.
// Instantiates lkv_ctrl and lkv_datapath; depends on lkv_pkg.
`default_nettype none

// Fully associative 16-entry key-value cache with least-recently-used
// replacement. Each input item is a get, put or contains request and gives
// exactly one result item: found, the value read on a get hit (else zero) and
// the entry count after the request. One request is handled at a time and
// goes through accept, parallel lookup over all entries and table commit;
// the next item is taken in the cycle after the commit. The result sits in
// an output register; while it waits to be taken the next item is still
// accepted and looked up, and only its commit waits. Capacity is written
// through cfg_we/cfg_wdata; the user must write it only while the block is
// idle, as the block itself does not enforce this. Values above 16 act as
// 16, and zero makes puts do nothing. Reset empties the table.
module lru_key_value_cache (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [4:0]  cfg_wdata,      // capacity
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [63:0] s_axis_tdata,   // [31:0] key, [63:32] value
	input  wire logic [1:0]  s_axis_tuser,   // [1:0] action
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [39:0]      m_axis_tdata,   // [31:0] read_value, [36:32] entry_count
	output logic [0:0]       m_axis_tuser    // [0] found
);

	lkv_pkg::ctrl_cmd_t  cmd;
	lkv_pkg::dp_status_t status;

	logic                               found;
	logic signed [lkv_pkg::VAL_W-1:0]   read_value;
	logic        [lkv_pkg::CNT_W-1:0]   entry_count;

	lkv_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	lkv_datapath u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.in_action       (s_axis_tuser),
		.in_key          (s_axis_tdata[31:0]),
		.in_value        (s_axis_tdata[63:32]),
		.out_valid       (m_axis_tvalid),
		.out_ready       (m_axis_tready),
		.out_found       (found),
		.out_read_value  (read_value),
		.out_entry_count (entry_count)
	);

	// Pack the result item
	assign m_axis_tdata = {3'b000, entry_count, read_value};
	assign m_axis_tuser = found;

endmodule

`default_nettype wire

// ===== design/lkv_checker.sv =====
// Port-level checks for the LRU key-value cache, bound to the top level.
// Depends on lkv_pkg and lru_key_value_cache.
`default_nettype none

module lkv_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [39:0] m_axis_tdata,
	input wire logic [0:0]  m_axis_tuser
);

	// A waiting result holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser))
		else $error("result changed while stalled");

	// Only one request in flight: no accept in the cycle after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("second item accepted during lookup");

	// Entry count never exceeds the table depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[36:32] <= 5'(lkv_pkg::ENTRIES))
		else $error("entry count above table depth");

	// A nonzero read value only comes with a hit
	a_value_hit: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[31:0] != 32'd0) |-> m_axis_tuser[0])
		else $error("read value without hit");

endmodule

bind lru_key_value_cache lkv_checker u_lkv_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// ===== sim/lkv_checker.sv =====
// Scoreboard for the LRU key-value cache: tracks its own copy of the table and
// capacity, predicts each result and compares it with the master-side stream.
// Depends on lkv_pkg; instantiated beside the cache by lru_key_value_cache_test.
`default_nettype none

module lkv_scoreboard (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [4:0]  cfg_wdata,
	input  wire logic        s_axis_tvalid,
	input  wire logic        s_axis_tready,
	input  wire logic [63:0] s_axis_tdata,   // [31:0] key, [63:32] value
	input  wire logic [1:0]  s_axis_tuser,   // [1:0] action
	input  wire logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	input  wire logic [39:0] m_axis_tdata,   // [31:0] read_value, [36:32] entry_count
	input  wire logic [0:0]  m_axis_tuser,   // [0] found
	output int               mismatches,
	output int               backlog
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic                      found;
		logic [lkv_pkg::VAL_W-1:0] read_value;
		logic [lkv_pkg::CNT_W-1:0] entry_count;
	} reply_t;

	// Shadow copy of the cache table
	logic [lkv_pkg::KEY_W-1:0] key_tbl [lkv_pkg::ENTRIES];
	logic [lkv_pkg::VAL_W-1:0] val_tbl [lkv_pkg::ENTRIES];
	logic                      entry_live [lkv_pkg::ENTRIES];
	int unsigned               age_rank [lkv_pkg::ENTRIES];
	int unsigned               held_count;
	int unsigned               capacity_reg;

	reply_t expected_replies [$];

	// Make slot s the most recent, aging every live entry that was newer.
	function automatic void make_recent(int s);
		int unsigned r;
		r = age_rank[s];
		for (int i = 0; i < lkv_pkg::ENTRIES; i++)
			if (entry_live[i] && i != s && age_rank[i] < r)
				age_rank[i]++;
		age_rank[s] = 0;
	endfunction

	// Apply one request to the shadow table and return the result it gives.
	function automatic reply_t serve_request(logic [lkv_pkg::ACT_W-1:0] act,
			logic [lkv_pkg::KEY_W-1:0] k, logic [lkv_pkg::VAL_W-1:0] v);
		reply_t      r;
		int          hit;
		int          slot;
		int unsigned eff_cap;
		r = '0;
		hit = -1;
		slot = -1;
		eff_cap = (capacity_reg > lkv_pkg::ENTRIES) ? lkv_pkg::ENTRIES : capacity_reg;
		for (int i = 0; i < lkv_pkg::ENTRIES; i++)
			if (hit < 0 && entry_live[i] && key_tbl[i] == k)
				hit = i;
		case (act)
			lkv_pkg::ACT_GET: begin
				if (hit >= 0) begin
					r.found = 1'b1;
					r.read_value = val_tbl[hit];
					make_recent(hit);
				end
			end
			lkv_pkg::ACT_PUT: begin
				r.found = (hit >= 0);
				if (eff_cap != 0) begin
					if (hit >= 0) begin
						val_tbl[hit] = v;
						make_recent(hit);
					end else if (held_count >= eff_cap) begin
						// replace the least recent entry in place
						for (int i = 0; i < lkv_pkg::ENTRIES; i++)
							if (entry_live[i] && (slot < 0 || age_rank[i] > age_rank[slot]))
								slot = i;
						if (slot >= 0) begin
							key_tbl[slot] = k;
							val_tbl[slot] = v;
							make_recent(slot);
						end
					end else begin
						// take the lowest free slot as the newest entry
						for (int i = 0; i < lkv_pkg::ENTRIES; i++)
							if (slot < 0 && !entry_live[i])
								slot = i;
						if (slot >= 0) begin
							for (int i = 0; i < lkv_pkg::ENTRIES; i++)
								if (entry_live[i])
									age_rank[i]++;
							entry_live[slot] = 1'b1;
							key_tbl[slot] = k;
							val_tbl[slot] = v;
							age_rank[slot] = 0;
							held_count++;
						end
					end
				end
			end
			lkv_pkg::ACT_CONTAINS: r.found = (hit >= 0);
			default: ;
		endcase
		r.entry_count = held_count[lkv_pkg::CNT_W-1:0];
		return r;
	endfunction

	// Track configuration, predict accepted items, and match results in order
	always @(posedge clk or negedge arst_n) begin
		reply_t got;
		reply_t want;
		int     bad;
		bad = 0;
		if (!arst_n) begin
			for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
				entry_live[i] = 1'b0;
				age_rank[i] = 0;
			end
			held_count = 0;
			capacity_reg = 16;
			expected_replies.delete();
			mismatches <= 0;
			backlog <= 0;
		end else begin
			if (cfg_we)
				capacity_reg = 32'(cfg_wdata);
			// retire the oldest expectation first
			if (m_axis_tvalid && m_axis_tready) begin
				got.found = m_axis_tuser[0];
				got.read_value = m_axis_tdata[31:0];
				got.entry_count = m_axis_tdata[36:32];
				if (expected_replies.size() == 0) begin
					$display("%0t: unexpected result: found=%0b value=%h count=%0d",
						$time, got.found, got.read_value, got.entry_count);
					bad = 1;
				end else begin
					want = expected_replies.pop_front();
					if (got !== want) begin
						$display({"%0t: result mismatch: expected found=%0b value=%h ",
							"count=%0d, got found=%0b value=%h count=%0d"},
							$time, want.found, want.read_value, want.entry_count,
							got.found, got.read_value, got.entry_count);
						bad = 1;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				expected_replies.push_back(serve_request(s_axis_tuser, s_axis_tdata[31:0],
					s_axis_tdata[63:32]));
			mismatches <= mismatches + bad;
			backlog <= expected_replies.size();
		end
	end

endmodule

`default_nettype wire

// ===== sim/lru_key_value_cache_test.sv =====
// Top of the LRU key-value cache testbench: clock, reset, request stimulus,
// capacity phases, result back-pressure and the final verdict.
// Depends on lkv_pkg, lru_key_value_cache and lkv_scoreboard.
`default_nettype none

module lru_key_value_cache_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [lkv_pkg::ACT_W-1:0] ACT_UNUSED = 2'd3;
	localparam int PHASE_ITEMS = 162;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [4:0]  cfg_wdata = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata = '0;   // [31:0] key, [63:32] value
	logic [1:0]  s_axis_tuser = '0;   // [1:0] action
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;        // [31:0] read_value, [36:32] entry_count
	logic [0:0]  m_axis_tuser;        // [0] found
	int          mismatches;
	int          backlog;

	logic [lkv_pkg::KEY_W-1:0] key_pool [32];
	bit                        send_calm = 1'b0;
	bit                        recv_calm = 1'b0;

	lru_key_value_cache u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	lkv_scoreboard u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.mismatches    (mismatches),
		.backlog       (backlog)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Present one request, hold it until taken, then idle for a random gap outside calm stretches.
	task automatic send_request(logic [lkv_pkg::ACT_W-1:0] act,
			logic [lkv_pkg::KEY_W-1:0] k, logic [lkv_pkg::VAL_W-1:0] v);
		int gap;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= act;
		s_axis_tdata <= {v, k};
		do @(posedge clk); while (!s_axis_tready);
		if ($urandom_range(0, 39) == 0)
			send_calm = !send_calm;
		gap = send_calm ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stop sending and hold until every predicted result has been taken.
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (backlog != 0);
	endtask

	task automatic set_capacity(logic [4:0] c);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= c;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Drain results with random stalls and stall-free stretches
	initial begin
		int stall;
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 39) == 0)
				recv_calm = !recv_calm;
			stall = recv_calm ? 0 : $urandom_range(0, 18);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	// Request stimulus and verdict
	initial begin
		logic [4:0]                phase_caps [12];
		int                        pool_size;
		int                        pick;
		logic [lkv_pkg::ACT_W-1:0] act;
		logic [lkv_pkg::KEY_W-1:0] k;

		key_pool[0] = 32'h8000_0000;
		key_pool[1] = 32'h7FFF_FFFF;
		key_pool[2] = 32'h0000_0000;
		key_pool[3] = 32'hFFFF_FFFF;
		for (int i = 4; i < 32; i++)
			key_pool[i] = $urandom;
		phase_caps = '{5'd0, 5'd1, 5'd31, 5'd3, 5'd17, 5'd16, 5'd2, 5'd8,
			5'd0, 5'd0, 5'd0, 5'd0};
		for (int i = 8; i < 12; i++)
			phase_caps[i] = 5'($urandom_range(0, 31));

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty table: misses and the unused action code
		send_request(lkv_pkg::ACT_CONTAINS, 32'h0000_0000, 32'h0000_0000);
		send_request(lkv_pkg::ACT_GET, 32'h8000_0000, 32'h0000_0000);
		send_request(ACT_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		// Extreme keys and values
		send_request(lkv_pkg::ACT_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
		send_request(lkv_pkg::ACT_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
		send_request(lkv_pkg::ACT_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
		send_request(lkv_pkg::ACT_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
		// Get hits ignore the value field, put hits overwrite it; contains leaves recency alone
		send_request(lkv_pkg::ACT_GET, 32'h8000_0000, 32'hFFFF_FFFF);
		send_request(lkv_pkg::ACT_CONTAINS, 32'h7FFF_FFFF, 32'h1234_5678);
		send_request(lkv_pkg::ACT_PUT, 32'h0000_0000, 32'h5A5A_5A5A);
		send_request(ACT_UNUSED, 32'h0000_0000, 32'hA5A5_A5A5);
		send_request(lkv_pkg::ACT_GET, 32'h0000_0000, 32'h0000_0000);
		// Fill the table, then force an eviction of the least recent key
		for (int i = 4; i < 17; i++)
			send_request(lkv_pkg::ACT_PUT, key_pool[i], $urandom);
		send_request(lkv_pkg::ACT_CONTAINS, 32'h7FFF_FFFF, 32'h0000_0000);

		// Random requests over a series of capacities, table kept across phases
		for (int p = 0; p < 12; p++) begin
			set_capacity(phase_caps[p]);
			pool_size = $urandom_range(2, 24);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				pick = $urandom_range(0, 99);
				act = (pick < 40) ? lkv_pkg::ACT_GET : (pick < 75) ? lkv_pkg::ACT_PUT :
					(pick < 95) ? lkv_pkg::ACT_CONTAINS : ACT_UNUSED;
				k = ($urandom_range(0, 9) == 0) ? $urandom :
					key_pool[$urandom_range(0, pool_size - 1)];
				send_request(act, k, $urandom);
				if ($urandom_range(0, 49) == 0)
					key_pool[$urandom_range(4, 31)] = $urandom;
				if ($urandom_range(0, 99) == 0)
					wait_drained();
			end
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && backlog == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// Guard against a hung handshake
	initial begin
		#4ms;
		$display("%0t: timeout with %0d results outstanding", $time, backlog);
		$display("Regression FAIL");
		$finish;
	end

endmodule

`default_nettype wire
